>>> hw/rtl/rgbc_pkg.sv
package rgbc_pkg;

   localparam int PIX_BITS   = 24;
   localparam int CH_BITS    = 8;
   localparam int DIM_BITS   = 11;
   localparam int POS_BITS   = 10;
   // Signed kernel coefficient width; three of them fill one kernel row register
   localparam int COEFF_BITS = 8;

   // Register byte addresses (register index times four)
   localparam logic [4:0] ADDR_KTOP    = 5'd0;
   localparam logic [4:0] ADDR_KMID    = 5'd4;
   localparam logic [4:0] ADDR_KBOT    = 5'd8;
   localparam logic [4:0] ADDR_DIVISOR = 5'd12;
   localparam logic [4:0] ADDR_WIDTH   = 5'd16;
   localparam logic [4:0] ADDR_HEIGHT  = 5'd20;

   // Queue entry: the 3x3 window plus the position of the centre pixel
   typedef struct packed {
      logic [8:0][PIX_BITS-1:0] win;
      logic [POS_BITS-1:0]      row;
      logic [POS_BITS-1:0]      col;
      logic                     last;
   } job_type;

   // Kernel and divisor handed to the back part
   typedef struct packed {
      logic [PIX_BITS-1:0] ktop;
      logic [PIX_BITS-1:0] kmid;
      logic [PIX_BITS-1:0] kbot;
      logic [CH_BITS-1:0]  divisor;
   } kern_type;

endpackage

>>> hw/rtl/rgbc_front.sv
module rgbc_front
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [PIX_BITS-1:0] in_pix,
   input  logic [DIM_BITS-1:0] cfg_width,
   input  logic [DIM_BITS-1:0] cfg_height,
   output logic                job_valid,
   input  logic                job_stall,
   output job_type             job
);
   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int CH = $clog2(MAX_HEIGHT + 1);
   localparam int AW = $clog2(MAX_WIDTH);

   logic [PIX_BITS-1:0] older_mem [MAX_WIDTH];
   logic [PIX_BITS-1:0] newer_mem [MAX_WIDTH];

   // Stage 1: beat captured, line store read issued
   logic                stg_valid_ff;
   logic [PIX_BITS-1:0] stg_pix_ff;
   logic [CW-1:0]       stg_col_ff;
   logic [CH-1:0]       stg_row_ff;
   logic                stg_inr_ff;
   logic [PIX_BITS-1:0] up2_ff, up1_ff;

   logic [CW-1:0] col_ff, col_in;
   logic [CH-1:0] row_ff, row_in;
   logic [2:0][2:0][PIX_BITS-1:0] win_ff, win_in;

   logic                job_valid_ff;
   job_type             job_ff;

   logic [CW-1:0] w_eff;
   logic [CH-1:0] h_eff;
   logic          accept, adv, out_free;
   logic          col_inrange;

   always_comb begin
      if (cfg_width < DIM_BITS'(3)) w_eff = CW'(3);
      else if (int'(cfg_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(cfg_width);
      if (cfg_height < DIM_BITS'(3)) h_eff = CH'(3);
      else if (int'(cfg_height) > MAX_HEIGHT) h_eff = CH'(MAX_HEIGHT);
      else h_eff = CH'(cfg_height);
   end

   // Stage 2 consumes stage 1 when the job register is free
   assign out_free = !job_valid_ff || !job_stall;
   assign adv      = stg_valid_ff && out_free;
   assign in_stall = stg_valid_ff && !out_free;
   assign accept   = in_valid && !in_stall;
   assign col_inrange = col_ff < CW'(MAX_WIDTH);

   // Counters advance per accepted beat
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = col_ff + CW'(1);
         if (col_in >= w_eff) begin
            col_in = '0;
            row_in = row_ff + CH'(1);
            if (row_in >= h_eff) row_in = '0;
         end
      end
   end

   // Line stores: read old contents and write new in the same beat
   always_ff @(posedge clock) begin
      if (accept && col_inrange) begin
         up2_ff <= older_mem[col_ff[AW-1:0]];
         up1_ff <= newer_mem[col_ff[AW-1:0]];
         older_mem[col_ff[AW-1:0]] <= newer_mem[col_ff[AW-1:0]];
         newer_mem[col_ff[AW-1:0]] <= in_pix;
      end else if (accept) begin
         up2_ff <= '0;
         up1_ff <= '0;
      end
   end

   // Window shift
   always_comb begin
      win_in = win_ff;
      for (int i = 0; i < 3; i++) begin
         win_in[i][0] = win_ff[i][1];
         win_in[i][1] = win_ff[i][2];
      end
      win_in[0][2] = up2_ff;
      win_in[1][2] = up1_ff;
      win_in[2][2] = stg_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         job_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         win_ff       <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            stg_valid_ff <= 1'b1;
            stg_pix_ff   <= in_pix;
            stg_col_ff   <= col_ff;
            stg_row_ff   <= row_ff;
            stg_inr_ff   <= row_ff >= CH'(2) && col_ff >= CW'(2)
                            && row_ff < h_eff && col_ff < w_eff;
         end else if (adv) begin
            stg_valid_ff <= 1'b0;
         end
         if (adv) begin
            win_ff       <= win_in;
            job_valid_ff <= stg_inr_ff;
            for (int i = 0; i < 3; i++)
               for (int j = 0; j < 3; j++)
                  job_ff.win[i*3+j] <= win_in[i][j];
            job_ff.row  <= POS_BITS'(stg_row_ff - CH'(1));
            job_ff.col  <= POS_BITS'(stg_col_ff - CW'(1));
            job_ff.last <= (stg_row_ff == h_eff - CH'(1)) && (stg_col_ff == w_eff - CW'(1));
         end else if (!job_stall) begin
            job_valid_ff <= 1'b0;
         end
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;
endmodule

>>> hw/rtl/rgbc_queue.sv
module rgbc_queue
   import rgbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_valid,
   output logic    wr_stall,
   input  job_type wr_data,
   output logic    rd_valid,
   input  logic    rd_stall,
   output job_type rd_data
);
   // Two-entry queue: full throughput with a registered stall
   job_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_stall = cnt_ff == 2'd2;
   assign rd_valid = cnt_ff != 2'd0;
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_valid && !rd_stall;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

>>> hw/rtl/rgbc_back.sv
module rgbc_back
   import rgbc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   output logic               job_stall,
   input  job_type            job,
   input  kern_type           kern,
   output logic               out_valid,
   input  logic               out_stall,
   output logic [CH_BITS-1:0] red,
   output logic [CH_BITS-1:0] green,
   output logic [CH_BITS-1:0] blue,
   output logic [POS_BITS-1:0] row,
   output logic [POS_BITS-1:0] col,
   output logic               last
);
   localparam int PB  = CH_BITS + COEFF_BITS + 1;
   localparam int SB  = PB + 4;
   localparam int QB  = SB;
   localparam int CNB = $clog2(QB + 1);

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM, S_DIV} state_type;

   state_type state_ff;
   logic [2:0][8:0][PB-1:0] prod_ff;
   logic [2:0][QB-1:0]      quo_ff;
   logic [2:0][CH_BITS:0]   rem_ff;
   logic [CNB-1:0]          cnt_ff;
   logic [CH_BITS-1:0]      div_ff;
   logic [POS_BITS-1:0]     row_ff, col_ff;
   logic                    last_ff;
   logic                    out_valid_ff;
   logic [2:0][CH_BITS-1:0] res_ff;
   logic [POS_BITS-1:0]     rsp_row_ff, rsp_col_ff;
   logic                    rsp_last_ff;
   logic [8:0][COEFF_BITS-1:0] coef;
   logic [2:0][SB-1:0]      sum_in;
   logic [2:0][CH_BITS:0]   rem_in;
   logic [2:0][QB-1:0]      quo_in;

   // Coefficients, row-major, left column in the low bits
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         coef[j]   = kern.ktop[j*COEFF_BITS +: COEFF_BITS];
         coef[3+j] = kern.kmid[j*COEFF_BITS +: COEFF_BITS];
         coef[6+j] = kern.kbot[j*COEFF_BITS +: COEFF_BITS];
      end
   end

   // Adder tree over the nine products per channel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = '0;
         for (int k = 0; k < 9; k++)
            sum_in[c] = sum_in[c] + SB'($signed(prod_ff[c][k]));
      end
   end

   // One restoring division bit per cycle, all channels in parallel
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         logic [CH_BITS+1:0] t;
         t = {rem_ff[c], quo_ff[c][QB-1]};
         quo_in[c] = {quo_ff[c][QB-2:0], 1'b0};
         if (t >= {2'b00, div_ff}) begin
            rem_in[c] = (CH_BITS+1)'(t - {2'b00, div_ff});
            quo_in[c][0] = 1'b1;
         end else begin
            rem_in[c] = t[CH_BITS:0];
         end
      end
   end

   assign job_stall = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         // Output beat: loaded from the divide state, dropped once taken
         if (state_ff == S_DIV && (!out_valid_ff || !out_stall)) out_valid_ff <= 1'b1;
         else if (out_valid_ff && !out_stall) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  for (int c = 0; c < 3; c++)
                     for (int k = 0; k < 9; k++)
                        prod_ff[c][k] <= PB'($signed({1'b0, job.win[k][c*CH_BITS +: CH_BITS]})
                                         * $signed(coef[k]));
                  div_ff  <= (kern.divisor == '0) ? CH_BITS'(1) : kern.divisor;
                  row_ff  <= job.row;
                  col_ff  <= job.col;
                  last_ff <= job.last;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               for (int c = 0; c < 3; c++) begin
                  quo_ff[c] <= $signed(sum_in[c]) > 0 ? sum_in[c] : '0;
                  rem_ff[c] <= '0;
               end
               cnt_ff   <= CNB'(QB);
               state_ff <= S_SUM;
            end
            S_SUM: begin
               quo_ff <= quo_in;
               rem_ff <= rem_in;
               cnt_ff <= cnt_ff - CNB'(1);
               if (cnt_ff == CNB'(1)) state_ff <= S_DIV;
            end
            S_DIV: begin
               // Wait for the output register, then clamp and present
               if (!out_valid_ff || !out_stall) begin
                  for (int c = 0; c < 3; c++)
                     res_ff[c] <= (quo_ff[c] > QB'(255)) ? CH_BITS'(255)
                                                         : quo_ff[c][CH_BITS-1:0];
                  rsp_row_ff  <= row_ff;
                  rsp_col_ff  <= col_ff;
                  rsp_last_ff <= last_ff;
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid = out_valid_ff;
   assign red   = res_ff[0];
   assign green = res_ff[1];
   assign blue  = res_ff[2];
   assign row   = rsp_row_ff;
   assign col   = rsp_col_ff;
   assign last  = rsp_last_ff;
endmodule

>>> hw/rtl/rgb_convolution_3x3.sv
// Pipeline: the front captures each beat and reads the line stores, then shifts the
// window into the job register; the queue holds jobs; the back multiplies, sums and
// divides at one quotient bit a cycle, taking no new job until it presents the last.
// Border pixels that yield no result pass the front at one per cycle unless it stalls.
// Reset: synchronous, active high; clears counters, window, queue and registers
// to their defaults. Line stores are not cleared.
module rgb_convolution_3x3
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [CH_BITS-1:0]  req_red_in,
   input  logic [CH_BITS-1:0]  req_green_in,
   input  logic [CH_BITS-1:0]  req_blue_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [CH_BITS-1:0]  rsp_red_out,
   output logic [CH_BITS-1:0]  rsp_green_out,
   output logic [CH_BITS-1:0]  rsp_blue_out,
   output logic [POS_BITS-1:0] rsp_out_row,
   output logic [POS_BITS-1:0] rsp_out_column,
   output logic                rsp_frame_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   kern_type            kern_ff;
   logic [DIM_BITS-1:0] width_ff, height_ff;
   job_type             fjob, qjob;
   logic                fvalid, fstall, qvalid, qstall;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         kern_ff.ktop    <= '0;
         kern_ff.kmid    <= PIX_BITS'(256);
         kern_ff.kbot    <= '0;
         kern_ff.divisor <= CH_BITS'(1);
         width_ff        <= DIM_BITS'(1024);
         height_ff       <= DIM_BITS'(1024);
      end else if (psel && penable && pwrite) begin
         case (paddr)
            ADDR_KTOP:    kern_ff.ktop    <= pwdata[PIX_BITS-1:0];
            ADDR_KMID:    kern_ff.kmid    <= pwdata[PIX_BITS-1:0];
            ADDR_KBOT:    kern_ff.kbot    <= pwdata[PIX_BITS-1:0];
            ADDR_DIVISOR: kern_ff.divisor <= pwdata[CH_BITS-1:0];
            ADDR_WIDTH:   width_ff        <= pwdata[DIM_BITS-1:0];
            ADDR_HEIGHT:  height_ff       <= pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         ADDR_KTOP:    prdata = {8'd0, kern_ff.ktop};
         ADDR_KMID:    prdata = {8'd0, kern_ff.kmid};
         ADDR_KBOT:    prdata = {8'd0, kern_ff.kbot};
         ADDR_DIVISOR: prdata = {24'd0, kern_ff.divisor};
         ADDR_WIDTH:   prdata = {21'd0, width_ff};
         ADDR_HEIGHT:  prdata = {21'd0, height_ff};
         default:      prdata = '0;
      endcase
   end
   assign pready = 1'b1;

   rgbc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset,
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_pix   ({req_blue_in, req_green_in, req_red_in}),
      .cfg_width (width_ff),
      .cfg_height(height_ff),
      .job_valid(fvalid),
      .job_stall(fstall),
      .job      (fjob)
   );

   rgbc_queue u_queue (
      .clock, .reset,
      .wr_valid(fvalid), .wr_stall(fstall), .wr_data(fjob),
      .rd_valid(qvalid), .rd_stall(qstall), .rd_data(qjob)
   );

   rgbc_back u_back (
      .clock, .reset,
      .job_valid(qvalid),
      .job_stall(qstall),
      .job      (qjob),
      .kern     (kern_ff),
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .red      (rsp_red_out),
      .green    (rsp_green_out),
      .blue     (rsp_blue_out),
      .row      (rsp_out_row),
      .col      (rsp_out_column),
      .last     (rsp_frame_last)
   );
endmodule

>>> tb/sv/testbench.sv
module testbench;
   import rgbc_pkg::*;

   localparam int LINE_MAX   = 1024;
   localparam int DRAIN_WAIT = 64;
   localparam int STALL_LIMIT = 6000;

   typedef struct {
      logic [CH_BITS-1:0]  red;
      logic [CH_BITS-1:0]  green;
      logic [CH_BITS-1:0]  blue;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
      logic                last;
   } conv_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [CH_BITS-1:0]  req_red_in = '0;
   logic [CH_BITS-1:0]  req_green_in = '0;
   logic [CH_BITS-1:0]  req_blue_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CH_BITS-1:0]  rsp_red_out;
   logic [CH_BITS-1:0]  rsp_green_out;
   logic [CH_BITS-1:0]  rsp_blue_out;
   logic [POS_BITS-1:0] rsp_out_row;
   logic [POS_BITS-1:0] rsp_out_column;
   logic                rsp_frame_last;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [4:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   // pixels waiting to be sent, results waiting to be seen
   logic [PIX_BITS-1:0] pixel_feed[$];
   conv_pixel_type      filtered_expect[$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int error_count = 0;
   int pixels_sent = 0;
   int results_seen = 0;
   int frames_sent = 0;
   int quiet_cycles = 0;

   // shadow of the block's registers and pipeline state
   logic [PIX_BITS-1:0] kern_row[3];
   logic [CH_BITS-1:0]  div_reg;
   logic [DIM_BITS-1:0] width_reg;
   logic [DIM_BITS-1:0] height_reg;
   logic [PIX_BITS-1:0] older_line[LINE_MAX];
   logic [PIX_BITS-1:0] newer_line[LINE_MAX];
   logic [PIX_BITS-1:0] window[3][3];
   int col_pos;
   int row_pos;

   rgb_convolution_3x3 i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      error_count++;
   endtask

   function automatic int clamp_dim(input logic [DIM_BITS-1:0] v);
      if (v < 3) return 3;
      if (v > LINE_MAX) return LINE_MAX;
      return int'(v);
   endfunction

   // weighted sum of one channel, truncating divide, clamp to 0..255
   function automatic logic [CH_BITS-1:0] filter_channel(input int shift);
      int sum;
      int cf;
      int pv;
      int q;
      int d;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            cf = $signed(kern_row[i][8*j +: 8]);
            pv = int'(window[i][j][shift +: 8]);
            sum += pv * cf;
         end
      end
      d = (div_reg == 0) ? 1 : int'(div_reg);
      if (sum <= 0) return '0;
      q = sum / d;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   // advance the shadow state by one pixel; queue a result for interior pixels
   task automatic predict_pixel(input logic [PIX_BITS-1:0] pix);
      int w;
      int h;
      logic [PIX_BITS-1:0] up2;
      logic [PIX_BITS-1:0] up1;
      conv_pixel_type e;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      up2 = '0;
      up1 = '0;
      if (col_pos < LINE_MAX) begin
         up2 = older_line[col_pos];
         up1 = newer_line[col_pos];
         older_line[col_pos] = up1;
         newer_line[col_pos] = pix;
      end
      for (int i = 0; i < 3; i++) begin
         window[i][0] = window[i][1];
         window[i][1] = window[i][2];
      end
      window[0][2] = up2;
      window[1][2] = up1;
      window[2][2] = pix;
      if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
         e.red   = filter_channel(0);
         e.green = filter_channel(8);
         e.blue  = filter_channel(16);
         e.row   = POS_BITS'(row_pos - 1);
         e.col   = POS_BITS'(col_pos - 1);
         e.last  = (row_pos == h - 1) && (col_pos == w - 1);
         filtered_expect.push_back(e);
      end
      col_pos++;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // pixel driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_pixel({req_blue_in, req_green_in, req_red_in});
            pixels_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pixel_feed.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               {req_blue_in, req_green_in, req_red_in} <= pixel_feed.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver stalls
   always @(posedge clock) begin
      conv_pixel_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (filtered_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected beat row %0d col %0d",
                                         rsp_out_row, rsp_out_column));
            end else begin
               e = filtered_expect.pop_front();
               if (rsp_red_out !== e.red)
                  report_mismatch($sformatf("red %0d exp %0d at (%0d,%0d)",
                                            rsp_red_out, e.red, e.row, e.col));
               if (rsp_green_out !== e.green)
                  report_mismatch($sformatf("green %0d exp %0d at (%0d,%0d)",
                                            rsp_green_out, e.green, e.row, e.col));
               if (rsp_blue_out !== e.blue)
                  report_mismatch($sformatf("blue %0d exp %0d at (%0d,%0d)",
                                            rsp_blue_out, e.blue, e.row, e.col));
               if (rsp_out_row !== e.row)
                  report_mismatch($sformatf("row %0d exp %0d", rsp_out_row, e.row));
               if (rsp_out_column !== e.col)
                  report_mismatch($sformatf("column %0d exp %0d", rsp_out_column, e.col));
               if (rsp_frame_last !== e.last)
                  report_mismatch($sformatf("frame_last %0b exp %0b at (%0d,%0d)",
                                            rsp_frame_last, e.last, e.row, e.col));
            end
         end
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // watchdog: cycles with no beat on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("rgb_convolution_3x3 verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(input logic [4:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (addr)
         ADDR_KTOP:    kern_row[0] = data[23:0];
         ADDR_KMID:    kern_row[1] = data[23:0];
         ADDR_KBOT:    kern_row[2] = data[23:0];
         ADDR_DIVISOR: div_reg = data[7:0];
         ADDR_WIDTH:   width_reg = data[10:0];
         ADDR_HEIGHT:  height_reg = data[10:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pixel_feed.size() != 0 || req_valid || filtered_expect.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic setup_frame(input logic [23:0] kt, input logic [23:0] km,
                              input logic [23:0] kb, input logic [7:0] dv,
                              input logic [10:0] w, input logic [10:0] h);
      wait_drained();
      csr_write(ADDR_KTOP, {8'($urandom), kt});
      csr_write(ADDR_KMID, {8'($urandom), km});
      csr_write(ADDR_KBOT, {8'($urandom), kb});
      csr_write(ADDR_DIVISOR, {24'($urandom), dv});
      csr_write(ADDR_WIDTH, {21'($urandom), w});
      csr_write(ADDR_HEIGHT, {21'($urandom), h});
   endtask

   function automatic logic [7:0] rand_sample();
      case ($urandom_range(5))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   // a whole frame of pixels at the current size
   task automatic queue_frame();
      int n;
      n = clamp_dim(width_reg) * clamp_dim(height_reg);
      for (int i = 0; i < n; i++)
         pixel_feed.push_back({rand_sample(), rand_sample(), rand_sample()});
      frames_sent++;
   endtask

   function automatic logic [23:0] rand_kernel_row();
      logic [23:0] k;
      if ($urandom_range(1)) begin
         for (int j = 0; j < 3; j++) k[8*j +: 8] = 8'($signed($urandom_range(8)) - 4);
         return k;
      end
      return 24'($urandom);
   endfunction

   initial begin
      kern_row[0] = 24'h0;
      kern_row[1] = 24'h000100;
      kern_row[2] = 24'h0;
      div_reg = 8'd1;
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      foreach (window[i, j]) window[i][j] = '0;
      col_pos = 0;
      row_pos = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: identity-like kernel on a 3x3 frame with extreme samples
      setup_frame(24'h0, 24'h000100, 24'h0, 8'd1, 11'd3, 11'd3);
      pixel_feed = '{24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FF00, 24'hA5FF5A,
                     24'h000000, 24'hFFFFFF, 24'h123456, 24'hFFFFFF};
      frames_sent++;
      // saturating kernel, zero divisor, undersized dimensions
      setup_frame(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 8'd0, 11'd2, 11'd0);
      queue_frame();
      // all most-negative coefficients, nonpositive sums
      setup_frame(24'h808080, 24'h808080, 24'h808080, 8'd255, 11'd4, 11'd3);
      queue_frame();

      // random frames under the three idling modes
      for (int mode = 0; mode < 3; mode++) begin
         tx_idle_pct = (mode == 0) ? 25 : (mode == 1) ? 79 : 0;
         rx_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 25 : 0;
         for (int f = 0; f < 5; f++) begin
            setup_frame(rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                        ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(16)),
                        11'($urandom_range(12)), 11'($urandom_range(2, 5)));
            queue_frame();
         end
      end
      wait_drained();

      $display("covered %0d frames, %0d pixels in, %0d filtered pixels checked",
               frames_sent, pixels_sent, results_seen);
      if (error_count == 0) begin
         $display("rgb_convolution_3x3 verification clean");
      end else begin
         $display("rgb_convolution_3x3 verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/rgbc_pkg.sv
hw/rtl/rgbc_front.sv
hw/rtl/rgbc_queue.sv
hw/rtl/rgbc_back.sv
hw/rtl/rgb_convolution_3x3.sv
tb/sv/testbench.sv
